@@ src/bres_pkg.sv @@
// ============================================================================
// bres_pkg: shared constants for the Bresenham line rasterizer
// Opcodes of the input beat and the row pitch register format.
// ============================================================================
package bres_pkg;

    // Row pitch register
    localparam int              PITCH_BITS  = 13;
    localparam logic [12:0]     PITCH_RESET = 13'd1280;

    // Input beat opcodes (carried in s_axis_tuser)
    localparam logic            OP_START    = 1'b0;
    localparam logic            OP_ADVANCE  = 1'b1;

endpackage

@@ src/bres_step.sv @@
// ============================================================================
// bres_step: line setup and per-pixel Bresenham step
// Holds the line state, runs setup on a start beat or one step on an advance
// beat, and registers the resulting pixel.
// ============================================================================
module bres_step #(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_opcode,
    input  logic [COORD_BITS-1:0] in_x_start,
    input  logic [COORD_BITS-1:0] in_y_start,
    input  logic [COORD_BITS-1:0] in_x_end,
    input  logic [COORD_BITS-1:0] in_y_end,
    input  logic [31:0]           in_color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_pixel_valid,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic [31:0]           out_color,
    output logic                  out_last,
    output logic                  line_active
);

    localparam int DW = COORD_BITS + 2;   // decision term and diagonal increment
    localparam int SW = COORD_BITS + 1;   // straight increment

    // line state
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] end_major_reg, end_major_next;
    logic [DW-1:0]         decision_reg, decision_next;
    logic [SW-1:0]         inc_straight_reg, inc_straight_next;
    logic [DW-1:0]         inc_diagonal_reg, inc_diagonal_next;
    logic                  minor_neg_reg, minor_neg_next;
    logic                  y_major_reg, y_major_next;
    logic                  line_active_reg, line_active_next;
    logic [31:0]           line_color_reg, line_color_next;

    // pixel register
    logic                  stage_vld_reg;
    logic                  pix_valid_reg, pix_valid_next;
    logic [COORD_BITS-1:0] pix_x_reg, pix_x_next;
    logic [COORD_BITS-1:0] pix_y_reg, pix_y_next;
    logic [31:0]           pix_color_reg, pix_color_next;
    logic                  pix_last_reg, pix_last_next;

    logic                  fire;

    // setup terms
    logic [COORD_BITS-1:0] dx, dy, dmaj, dmin;
    logic                  x_major, swap;
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic                  start_last;

    // step terms
    logic [COORD_BITS-1:0] maj, mnr, maj_inc, mnr_step;
    logic                  straight, step_last;
    logic [DW-1:0]         dec_step;

    assign in_ready = !stage_vld_reg || out_ready;
    assign fire     = in_valid && in_ready;

    always_comb begin
        dx      = (in_x_start > in_x_end) ? (in_x_start - in_x_end) : (in_x_end - in_x_start);
        dy      = (in_y_start > in_y_end) ? (in_y_start - in_y_end) : (in_y_end - in_y_start);
        x_major = dx > dy;
        dmaj    = x_major ? dx : dy;
        dmin    = x_major ? dy : dx;
        // walk from the endpoint with the smaller major coordinate
        swap    = x_major ? (in_x_start > in_x_end) : (in_y_start > in_y_end);
        sx      = swap ? in_x_end   : in_x_start;
        sy      = swap ? in_y_end   : in_y_start;
        ex      = swap ? in_x_start : in_x_end;
        ey      = swap ? in_y_start : in_y_end;
        start_last = x_major ? (sx == ex) : (sy == ey);
    end

    always_comb begin
        maj      = y_major_reg ? cur_y_reg : cur_x_reg;
        mnr      = y_major_reg ? cur_x_reg : cur_y_reg;
        maj_inc  = maj + 1'b1;
        straight = decision_reg[DW-1];
        if (straight) begin
            mnr_step = mnr;
            dec_step = decision_reg + {1'b0, inc_straight_reg};
        end else begin
            mnr_step = minor_neg_reg ? (mnr - 1'b1) : (mnr + 1'b1);
            dec_step = decision_reg + inc_diagonal_reg;
        end
        step_last = maj_inc == end_major_reg;
    end

    always_comb begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        end_major_next    = end_major_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        minor_neg_next    = minor_neg_reg;
        y_major_next      = y_major_reg;
        line_active_next  = line_active_reg;
        line_color_next   = line_color_reg;
        pix_valid_next    = 1'b0;
        pix_x_next        = '0;
        pix_y_next        = '0;
        pix_color_next    = '0;
        pix_last_next     = 1'b0;
        if (in_opcode == bres_pkg::OP_START) begin
            cur_x_next        = sx;
            cur_y_next        = sy;
            end_major_next    = x_major ? ex : ey;
            decision_next     = {1'b0, dmin, 1'b0} - {2'b00, dmaj};
            inc_straight_next = {dmin, 1'b0};
            inc_diagonal_next = {1'b0, dmin, 1'b0} - {1'b0, dmaj, 1'b0};
            minor_neg_next    = x_major ? (ey < sy) : (ex < sx);
            y_major_next      = !x_major;
            line_active_next  = !start_last;
            line_color_next   = in_color;
            pix_valid_next    = 1'b1;
            pix_x_next        = sx;
            pix_y_next        = sy;
            pix_color_next    = in_color;
            pix_last_next     = start_last;
        end else if (line_active_reg) begin
            cur_x_next       = y_major_reg ? mnr_step : maj_inc;
            cur_y_next       = y_major_reg ? maj_inc  : mnr_step;
            decision_next    = dec_step;
            line_active_next = !step_last;
            pix_valid_next   = 1'b1;
            pix_x_next       = cur_x_next;
            pix_y_next       = cur_y_next;
            pix_color_next   = line_color_reg;
            pix_last_next    = step_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            stage_vld_reg   <= 1'b0;
        end else begin
            if (fire) begin
                line_active_reg <= line_active_next;
            end
            if (fire) begin
                stage_vld_reg <= 1'b1;
            end else if (out_ready) begin
                stage_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            end_major_reg    <= end_major_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            minor_neg_reg    <= minor_neg_next;
            y_major_reg      <= y_major_next;
            line_color_reg   <= line_color_next;
            pix_valid_reg    <= pix_valid_next;
            pix_x_reg        <= pix_x_next;
            pix_y_reg        <= pix_y_next;
            pix_color_reg    <= pix_color_next;
            pix_last_reg     <= pix_last_next;
        end
    end

    assign out_valid       = stage_vld_reg;
    assign out_pixel_valid = pix_valid_reg;
    assign out_x           = pix_x_reg;
    assign out_y           = pix_y_reg;
    assign out_color       = pix_color_reg;
    assign out_last        = pix_last_reg;
    assign line_active     = line_active_reg;

endmodule

@@ src/bres_addr.sv @@
// ============================================================================
// bres_addr: pixel word address and result register
// Computes y * pitch + x for the registered pixel and holds the result beat.
// ============================================================================
module bres_addr #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [bres_pkg::PITCH_BITS-1:0] pitch,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            in_pixel_valid,
    input  logic [COORD_BITS-1:0]           in_x,
    input  logic [COORD_BITS-1:0]           in_y,
    input  logic [31:0]                     in_color,
    input  logic                            in_last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_pixel_valid,
    output logic [COORD_BITS-1:0]           out_x,
    output logic [COORD_BITS-1:0]           out_y,
    output logic [ADDR_BITS-1:0]            out_addr,
    output logic [31:0]                     out_color,
    output logic                            out_last
);

    localparam int PROD_BITS = COORD_BITS + bres_pkg::PITCH_BITS;
    localparam int SUM_BITS  = (ADDR_BITS > PROD_BITS + 1) ? ADDR_BITS : PROD_BITS + 1;

    logic                  vld_reg;
    logic                  pix_valid_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [31:0]           color_reg;
    logic                  last_reg;

    logic [PROD_BITS-1:0]  prod;
    logic [SUM_BITS-1:0]   addr_sum;
    logic                  fire;

    assign in_ready = !vld_reg || out_ready;
    assign fire     = in_valid && in_ready;

    // address wraps to ADDR_BITS
    assign prod     = PROD_BITS'(in_y) * PROD_BITS'(pitch);
    assign addr_sum = SUM_BITS'(prod) + SUM_BITS'(in_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (fire) begin
            vld_reg <= 1'b1;
        end else if (out_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            pix_valid_reg <= in_pixel_valid;
            x_reg         <= in_x;
            y_reg         <= in_y;
            addr_reg      <= addr_sum[ADDR_BITS-1:0];
            color_reg     <= in_color;
            last_reg      <= in_last;
        end
    end

    assign out_valid       = vld_reg;
    assign out_pixel_valid = pix_valid_reg;
    assign out_x           = x_reg;
    assign out_y           = y_reg;
    assign out_addr        = addr_reg;
    assign out_color       = color_reg;
    assign out_last        = last_reg;

endmodule

@@ src/bresenham_line_rasterizer_core.sv @@
// ============================================================================
// bresenham_line_rasterizer_core: Bresenham line rasterizer, top level
// Start beats set up a line and return its first pixel; advance beats return
// the following pixels with their framebuffer word address.
// ============================================================================
//
//  Channel   Direction  Payload
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         tuser: opcode; tdata: x_start, y_start, x_end, y_end,
//                       color
//  m_axis    out        tuser: pixel_valid; tlast: last_pixel;
//                       tdata: pixel_x, pixel_y, pixel_addr, pixel_color
//  cfg       in         cfg_wr_data: row_pitch_pixels
//
//  One beat per cycle in and out while m_axis_tready is high; an accepted input beat
//  passes the input register, step register and address register to m_axis_tvalid.
//  The loop that limits rate is the registered decision/coordinate update.
//  Each stage holds its beat while the next one is full, so a stalled m_axis
//  still lets the stages upstream fill.
//  aresetn (synchronous) makes the block idle and sets the pitch to 1280.
//
module bresenham_line_rasterizer_core #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [bres_pkg::PITCH_BITS-1:0] cfg_wr_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // x_start, y_start, x_end, y_end, color (low bit up), zero padded
    input  logic [((4*COORD_BITS+32+7)/8)*8-1:0] s_axis_tdata,
    input  logic                            s_axis_tuser,   // opcode
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_x, pixel_y, pixel_addr, pixel_color (low bit up), zero padded
    output logic [((2*COORD_BITS+ADDR_BITS+32+7)/8)*8-1:0] m_axis_tdata,
    output logic                            m_axis_tuser,   // pixel_valid
    output logic                            m_axis_tlast    // last_pixel
);

    localparam int C          = COORD_BITS;
    localparam int OUT_BITS   = ((2*COORD_BITS+ADDR_BITS+32+7)/8)*8;

    logic [bres_pkg::PITCH_BITS-1:0] pitch_reg;

    // input register
    logic          in_vld_reg;
    logic          op_reg;
    logic [C-1:0]  xs_reg, ys_reg, xe_reg, ye_reg;
    logic [31:0]   color_reg;
    logic          s_fire;

    // step -> address
    logic          step_ready, step_valid, step_pix_valid, step_last, line_active;
    logic [C-1:0]  step_x, step_y;
    logic [31:0]   step_color;
    logic          addr_ready;

    // address -> port
    logic          res_pix_valid, res_last;
    logic [C-1:0]  res_x, res_y;
    logic [ADDR_BITS-1:0] res_addr;
    logic [31:0]   res_color;

    assign s_axis_tready = !in_vld_reg || step_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg  <= bres_pkg::PITCH_RESET;
            in_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                pitch_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                in_vld_reg <= 1'b1;
            end else if (step_ready) begin
                in_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg    <= s_axis_tuser;
            xs_reg    <= s_axis_tdata[C-1:0];
            ys_reg    <= s_axis_tdata[2*C-1:C];
            xe_reg    <= s_axis_tdata[3*C-1:2*C];
            ye_reg    <= s_axis_tdata[4*C-1:3*C];
            color_reg <= s_axis_tdata[4*C+31:4*C];
        end
    end

    bres_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (in_vld_reg),
        .in_ready        (step_ready),
        .in_opcode       (op_reg),
        .in_x_start      (xs_reg),
        .in_y_start      (ys_reg),
        .in_x_end        (xe_reg),
        .in_y_end        (ye_reg),
        .in_color        (color_reg),
        .out_valid       (step_valid),
        .out_ready       (addr_ready),
        .out_pixel_valid (step_pix_valid),
        .out_x           (step_x),
        .out_y           (step_y),
        .out_color       (step_color),
        .out_last        (step_last),
        .line_active     (line_active)
    );

    bres_addr #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_addr (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .pitch           (pitch_reg),
        .in_valid        (step_valid),
        .in_ready        (addr_ready),
        .in_pixel_valid  (step_pix_valid),
        .in_x            (step_x),
        .in_y            (step_y),
        .in_color        (step_color),
        .in_last         (step_last),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_pixel_valid (res_pix_valid),
        .out_x           (res_x),
        .out_y           (res_y),
        .out_addr        (res_addr),
        .out_color       (res_color),
        .out_last        (res_last)
    );

    assign m_axis_tdata = OUT_BITS'({res_color, res_addr, res_y, res_x});
    assign m_axis_tuser = res_pix_valid;
    assign m_axis_tlast = res_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a last pixel is always a real pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("last flag on an empty result beat");

    // an advance with no line returns an all-zero beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("empty result beat carries data");

    // a pixel flagged last leaves the line inactive
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(step_ready && in_vld_reg) && step_last |-> !line_active)
    else $error("line still active after its last pixel");

    // reset empties the result register
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

@@ dv/bresenham_line_rasterizer_checker.sv @@
// ============================================================================
// bresenham_line_rasterizer_checker: pixel stream scoreboard
// Watches the config port and both streams of the rasterizer. It keeps its own
// line walker to predict the pixel for every accepted input beat, then checks
// each result beat field by field against the oldest predicted pixel.
// ============================================================================
module bresenham_line_rasterizer_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bres_pkg::PITCH_BITS-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [79:0]           s_tdata,    // x_start, y_start, x_end, y_end, color
    input  logic                  s_tuser,    // opcode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [79:0]           m_tdata,    // pixel_x, pixel_y, pixel_addr, pixel_color
    input  logic                  m_tuser,    // pixel_valid
    input  logic                  m_tlast,    // last_pixel
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic        valid;
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] addr;
        logic [31:0] color;
        logic        last;
    } pixel_t;

    pixel_t expected_pixels[$];
    int     errors = 0;

    // line walker state
    logic [bres_pkg::PITCH_BITS-1:0] pitch;
    logic [11:0]           pos_x;
    logic [11:0]           pos_y;
    logic [11:0]           stop_major;
    logic signed [14:0]    err_term;
    logic [13:0]           step_straight;
    logic signed [14:0]    step_diag;
    logic                  minor_down;
    logic                  walk_y;
    logic                  drawing;
    logic [31:0]           ink;

    task automatic report_mismatch(input string msg);
        if (errors < 100)
            $display("[%0t] pixel check: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    function automatic pixel_t rasterize(input logic op, input logic [79:0] beat);
        int          xa, ya, xb, yb, dx, dy;
        logic        at_end;
        logic [47:0] full;
        pixel_t      px;
        if (op == bres_pkg::OP_START) begin
            xa = int'(beat[11:0]);
            ya = int'(beat[23:12]);
            xb = int'(beat[35:24]);
            yb = int'(beat[47:36]);
            dx = xa > xb ? xa - xb : xb - xa;
            dy = ya > yb ? ya - yb : yb - ya;
            ink = beat[79:48];
            walk_y = !(dx > dy);   // ties and zero length go y-major
            if (!walk_y) begin
                err_term      = 15'(2 * dy - dx);
                step_straight = 14'(2 * dy);
                step_diag     = 15'(2 * (dy - dx));
                if (xa > xb) begin
                    pos_x = 12'(xb); pos_y = 12'(yb); stop_major = 12'(xa);
                    minor_down = ya < yb;
                end else begin
                    pos_x = 12'(xa); pos_y = 12'(ya); stop_major = 12'(xb);
                    minor_down = yb < ya;
                end
            end else begin
                err_term      = 15'(2 * dx - dy);
                step_straight = 14'(2 * dx);
                step_diag     = 15'(2 * (dx - dy));
                if (ya > yb) begin
                    pos_x = 12'(xb); pos_y = 12'(yb); stop_major = 12'(ya);
                    minor_down = xa < xb;
                end else begin
                    pos_x = 12'(xa); pos_y = 12'(ya); stop_major = 12'(yb);
                    minor_down = xb < xa;
                end
            end
        end else if (!drawing) begin
            return '0;
        end else begin
            if (walk_y) pos_y = pos_y + 12'd1;
            else        pos_x = pos_x + 12'd1;
            if (err_term[14]) begin
                err_term = err_term + 15'(step_straight);
            end else begin
                if (walk_y) pos_x = minor_down ? pos_x - 12'd1 : pos_x + 12'd1;
                else        pos_y = minor_down ? pos_y - 12'd1 : pos_y + 12'd1;
                err_term = err_term + step_diag;
            end
        end
        at_end  = (walk_y ? pos_y : pos_x) == stop_major;
        drawing = !at_end;
        full    = 48'(pos_y) * 48'(pitch) + 48'(pos_x);
        px.valid = 1'b1;
        px.x     = pos_x;
        px.y     = pos_y;
        px.addr  = full[23:0];
        px.color = ink;
        px.last  = at_end;
        return px;
    endfunction

    always @(posedge aclk) begin
        pixel_t want;
        if (!aresetn) begin
            pitch         = bres_pkg::PITCH_RESET;
            pos_x         = '0;
            pos_y         = '0;
            stop_major    = '0;
            err_term      = '0;
            step_straight = '0;
            step_diag     = '0;
            minor_down    = 1'b0;
            walk_y        = 1'b0;
            drawing       = 1'b0;
            ink           = '0;
            expected_pixels.delete();
        end else begin
            if (cfg_wr_en)
                pitch = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_pixels.push_back(rasterize(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result beat with no pixel expected");
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_valid", 32'(want.valid), 32'(m_tuser));
                    check_field("pixel_x",     32'(want.x),     32'(m_tdata[11:0]));
                    check_field("pixel_y",     32'(want.y),     32'(m_tdata[23:12]));
                    check_field("pixel_addr",  32'(want.addr),  32'(m_tdata[47:24]));
                    check_field("pixel_color", want.color,      m_tdata[79:48]);
                    check_field("last_pixel",  32'(want.last),  32'(m_tlast));
                end
            end
        end
        fail_count <= errors;
        pending    <= expected_pixels.size();
    end

endmodule

@@ dv/tb_bresenham_line_rasterizer_core.sv @@
// ============================================================================
// tb_bresenham_line_rasterizer_core: regression bench for the line rasterizer
// Directed lines cover idle advances, zero-length lines, both major axes,
// ties, reversed endpoints, restarts and screen corners; then random lines
// run under a series of row pitches, extremes and wraparound included, with
// random gaps on the input and random stalls on the output in all but one phase.
// ============================================================================
module tb_bresenham_line_rasterizer_core;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 240;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [bres_pkg::PITCH_BITS-1:0] cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [79:0]           s_axis_tdata;   // x_start, y_start, x_end, y_end, color
    logic                  s_axis_tuser;   // opcode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [79:0]           m_axis_tdata;   // pixel_x, pixel_y, pixel_addr, pixel_color
    logic                  m_axis_tuser;   // pixel_valid
    logic                  m_axis_tlast;   // last_pixel
    logic                  steady;         // no gaps or stalls while set
    int                    fail_count;
    int                    pending;
    int                    cycle_count;

    bresenham_line_rasterizer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bresenham_line_rasterizer_checker pixel_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .m_tlast     (m_axis_tlast),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("bresenham_line_rasterizer_core regression: fail");
        $finish;
    end

    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    // valid is left high after the accepting edge; the next call either
    // presents a new beat or drops it, so it is assigned once per step
    task automatic send_beat(input logic op, input logic [11:0] xa, ya, xb, yb,
                             input logic [31:0] color);
        while (!steady && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {color, yb, xb, ya, xa};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // coordinates are don't-care on advance; drive junk so they toggle
    task automatic advance_beat();
        send_beat(bres_pkg::OP_ADVANCE, 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), $urandom());
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);   // pipeline depth plus margin
    endtask

    function automatic logic [11:0] pick_anchor();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 12'd0;
        if (r == 1) return 12'hfff;
        return 12'($urandom);
    endfunction

    function automatic logic [11:0] near(input logic [11:0] base, input int span);
        int v;
        v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)         v = 0;
        else if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    initial begin
        logic [bres_pkg::PITCH_BITS-1:0] pitch_plan [8];
        logic [11:0]           xa, ya, xb, yb;
        int                    beats, pick, span, steps, cut, dx, dy, major_len;

        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= bres_pkg::OP_START;
        steady        <= 1'b0;
        // 0 and 8191 are the extremes of the pitch field; 8191 also wraps the address
        pitch_plan = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'($urandom_range(1, 4096)),
                       13'd640, 13'd4095, 13'($urandom_range(2, 8190))};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed lines, reset pitch
        advance_beat();                                            // idle advance
        send_beat(bres_pkg::OP_START, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0);   // zero length
        advance_beat();
        send_beat(bres_pkg::OP_START, 12'hfff, 12'hfff, 12'hfff, 12'hfff, 32'hffff_ffff);
        send_beat(bres_pkg::OP_START, 12'd0, 12'd0, 12'd5, 12'd2, 32'h1234_5678);
        repeat (6) advance_beat();                                 // runs one past the end
        // tie, reversed
        send_beat(bres_pkg::OP_START, 12'd3, 12'd10, 12'd6, 12'd7, 32'h5a5a_0ff0);
        advance_beat();
        // restart mid-line, full-screen diagonal
        send_beat(bres_pkg::OP_START, 12'hfff, 12'd0, 12'd0, 12'hfff, 32'ha5a5_a5a5);
        repeat (3) advance_beat();
        send_beat(bres_pkg::OP_START, 12'd2, 12'd100, 12'd0, 12'd0, 32'h0000_0001);
        repeat (2) advance_beat();
        send_beat(bres_pkg::OP_START, 12'hfff, 12'd7, 12'hffa, 12'd9, 32'h8000_0000);
        repeat (5) advance_beat();

        for (int p = 0; p < 8; p++) begin
            drain_results();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= pitch_plan[p];
            steady      <= (p == 2);
            @(posedge aclk);
            cfg_wr_en   <= 1'b0;
            beats = 0;
            while (beats < PHASE_BEATS) begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    advance_beat();   // stray advance
                    beats++;
                end else begin
                    span = pick < 70 ? 8 : (pick < 92 ? 40 : 400);
                    xa = pick_anchor();
                    ya = pick_anchor();
                    xb = near(xa, span);
                    yb = near(ya, span);
                    send_beat(bres_pkg::OP_START, xa, ya, xb, yb, $urandom());
                    beats++;
                    dx = xa > xb ? int'(xa - xb) : int'(xb - xa);
                    dy = ya > yb ? int'(ya - yb) : int'(yb - ya);
                    major_len = dx > dy ? dx : dy;
                    cut = $urandom_range(0, 99);
                    if (cut < 12)      steps = $urandom_range(0, major_len);   // abandoned
                    else if (cut < 25) steps = major_len + $urandom_range(1, 2);
                    else               steps = major_len;
                    // the phase ends at its beat budget; a long line is cut there
                    if (steps > PHASE_BEATS - beats) steps = PHASE_BEATS - beats;
                    repeat (steps) begin
                        advance_beat();
                        beats++;
                    end
                end
            end
        end
        drain_results();

        if (fail_count == 0)
            $display("bresenham_line_rasterizer_core regression: pass");
        else
            $display("bresenham_line_rasterizer_core regression: fail");
        $finish;
    end

endmodule
